// ----- rtl/hgt_pkg.sv -----
// Shared types, codes and helper functions of the generational handle table.
package hgt_pkg;

  localparam logic [2:0] REQ_REGISTER   = 3'd0;
  localparam logic [2:0] REQ_UNREGISTER = 3'd1;
  localparam logic [2:0] REQ_RESTORE    = 3'd2;
  localparam logic [2:0] REQ_SET_STATE  = 3'd3;
  localparam logic [2:0] REQ_CLASSIFY   = 3'd4;
  localparam logic [2:0] REQ_RESERVE    = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BADARG    = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;

  localparam logic [1:0] VAL_VALID   = 2'd0;
  localparam logic [1:0] VAL_NULL    = 2'd1;
  localparam logic [1:0] VAL_UNKNOWN = 2'd2;
  localparam logic [1:0] VAL_STALE   = 2'd3;

  localparam logic [2:0] LC_CONSTRUCTED = 3'd0;
  localparam logic [2:0] LC_REGISTERED  = 3'd1;
  localparam logic [2:0] LC_INITIALIZED = 3'd2;
  localparam logic [2:0] LC_ACTIVE      = 3'd3;
  localparam logic [2:0] LC_PENDING     = 3'd4;
  localparam logic [2:0] LC_MAX         = 3'd5;

  localparam int HGEN_W = 16;
  localparam int BASE_W = 10;
  localparam logic [BASE_W-1:0] BASE_RESET = 10'd512;

  // Classification of a request made on acceptance.
  typedef struct packed {
    logic [2:0] req;
    logic       badarg;
    logic       in_tab;
    logic       is_null;
  } hgt_cls_t;

  localparam int CLS_W = $bits(hgt_cls_t);

  function automatic logic legal_move(input logic [2:0] from, input logic [2:0] to);
    logic ok;
    case (from)
      LC_REGISTERED:  ok = (to == LC_INITIALIZED) || (to == LC_PENDING);
      LC_INITIALIZED: ok = (to == LC_ACTIVE) || (to == LC_PENDING);
      LC_ACTIVE:      ok = (to == LC_PENDING);
      default:        ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- rtl/hgt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hgt_front.sv -----
// Front end: argument checks and classification of each incoming request.
module hgt_front import hgt_pkg::*; #(
  parameter int IDX_W    = 10,
  parameter int IDS      = 1024,
  parameter int GEN_BITS = 16
) (
  input  logic [2:0]        req_type,
  input  logic [31:0]       entity_id,
  input  logic [HGEN_W-1:0] handle_gen,
  input  logic [2:0]        state_value,
  output hgt_cls_t          cls,
  output logic [IDX_W-1:0]  idx
);

  localparam logic [32:0] GMAX = (33'd1 << GEN_BITS) - 33'd1;

  logic id_zero, gen_zero, sv_bad, gen_big;

  always_comb begin
    id_zero  = (entity_id == 32'd0);
    gen_zero = (handle_gen == '0);
    sv_bad   = (state_value > LC_MAX);
    gen_big  = (33'(handle_gen) > GMAX);
    cls.req     = req_type;
    cls.in_tab  = (33'(entity_id) < 33'(IDS));
    cls.is_null = id_zero || gen_zero;
    case (req_type)
      REQ_REGISTER:   cls.badarg = id_zero;
      REQ_RESTORE:    cls.badarg = id_zero || gen_zero || gen_big || sv_bad;
      REQ_UNREGISTER: cls.badarg = id_zero || gen_zero;
      REQ_SET_STATE:  cls.badarg = id_zero || gen_zero || sv_bad;
      REQ_CLASSIFY:   cls.badarg = 1'b0;
      REQ_RESERVE:    cls.badarg = 1'b0;
      default:        cls.badarg = 1'b1;
    endcase
    idx = entity_id[IDX_W-1:0];
  end

endmodule

// ----- rtl/hgt_queue.sv -----
// Two-entry queue between the front end and the table sequencer.
module hgt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    head    = slot_r[rp_r];
    empty   = (cnt_r == 2'd0);
    full    = (cnt_r == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- rtl/hgt_back.sv -----
// Table sequencer: clears the table, executes requests, scans for free ids.
module hgt_back import hgt_pkg::*; #(
  parameter int IDS      = 1024,
  parameter int IDX_W    = 10,
  parameter int GEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hgt_cls_t            q_cls,
  input  logic [IDX_W-1:0]    q_idx,
  input  logic [HGEN_W-1:0]   q_gen,
  input  logic [2:0]          q_sv,
  output logic                q_pop,
  input  logic [BASE_W-1:0]   reserve_base,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [31:0]         out_id,
  output logic [HGEN_W-1:0]   out_gen,
  output logic [1:0]          out_validity,
  output logic [2:0]          out_lifecycle,
  output logic [IDX_W:0]      out_live_count,
  output logic [31:0]         out_destroyed_count
);

  localparam int W  = 1 + 2 * GEN_BITS + 3;
  localparam int SW = ((IDX_W > BASE_W) ? IDX_W : BASE_W) + 1;
  localparam logic [GEN_BITS-1:0] GFULL = '1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXE  = 7'b0000100,
    S_SRD  = 7'b0001000,
    S_SCHK = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_SPARE = 7'b1000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  hgt_cls_t           cls_r, cls_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [HGEN_W-1:0]  gen_r, gen_nxt;
  logic [2:0]         sv_r, sv_nxt;
  logic [SW-1:0]      scan_r, scan_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic [IDX_W:0]     live_r, live_nxt;
  logic [31:0]        dest_r, dest_nxt;

  logic [2:0]         rs_status_r, rs_status_nxt;
  logic [31:0]        rs_id_r, rs_id_nxt;
  logic [HGEN_W-1:0]  rs_gen_r, rs_gen_nxt;
  logic [1:0]         rs_val_r, rs_val_nxt;
  logic [2:0]         rs_life_r, rs_life_nxt;

  logic               ov_r, ov_nxt;
  logic [2:0]         o_status_r;
  logic [31:0]        o_id_r;
  logic [HGEN_W-1:0]  o_gen_r;
  logic [1:0]         o_val_r;
  logic [2:0]         o_life_r;
  logic [IDX_W:0]     o_live_r;
  logic [31:0]        o_dest_r;
  logic               o_load;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [W-1:0]       wdata, rdata;

  logic                rd_live, nw_live;
  logic [GEN_BITS-1:0] rd_last, rd_egen, nw_last, nw_egen;
  logic [2:0]          rd_ls, nw_ls;
  logic                gen_match;
  logic [BASE_W-1:0]   base_eff;
  logic [SW-1:0]       start;
  logic [SW-1:0]       scan_inc;

  hgt_ram #(.WIDTH(W), .DEPTH(IDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    {rd_live, rd_last, rd_egen, rd_ls} = rdata;
    gen_match = (33'(rd_egen) == 33'(gen_r));
    base_eff  = (reserve_base == '0) ? BASE_W'(1) : reserve_base;
    start     = (cursor_r == '0) ? SW'(base_eff) : SW'(cursor_r);
    scan_inc  = scan_r + SW'(1);

    state_nxt  = state_r;
    cls_nxt    = cls_r;
    idx_nxt    = idx_r;
    gen_nxt    = gen_r;
    sv_nxt     = sv_r;
    scan_nxt   = scan_r;
    clr_nxt    = clr_r;
    cursor_nxt = cursor_r;
    live_nxt   = live_r;
    dest_nxt   = dest_r;
    rs_status_nxt = rs_status_r;
    rs_id_nxt     = rs_id_r;
    rs_gen_nxt    = rs_gen_r;
    rs_val_nxt    = rs_val_r;
    rs_life_nxt   = rs_life_r;
    q_pop = 1'b0;
    we    = 1'b0;
    waddr = idx_r;
    raddr = q_idx;
    nw_live = rd_live;
    nw_last = rd_last;
    nw_egen = rd_egen;
    nw_ls   = rd_ls;
    o_load  = 1'b0;

    case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        nw_live = 1'b0;
        nw_last = '0;
        nw_egen = '0;
        nw_ls   = LC_CONSTRUCTED;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(IDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cls_nxt = q_cls;
          idx_nxt = q_idx;
          gen_nxt = q_gen;
          sv_nxt  = q_sv;
          rs_status_nxt = ST_OK;
          rs_id_nxt     = '0;
          rs_gen_nxt    = '0;
          rs_val_nxt    = VAL_VALID;
          rs_life_nxt   = LC_CONSTRUCTED;
          if (q_cls.req == REQ_RESERVE) begin
            scan_nxt = start;
            if (start < SW'(IDS)) begin
              state_nxt = S_SRD;
            end else begin
              rs_status_nxt = ST_RANGE;
              state_nxt     = S_OUT;
            end
          end else begin
            state_nxt = S_EXE;
          end
        end
      end
      S_EXE: begin
        state_nxt = S_OUT;
        case (cls_r.req)
          REQ_REGISTER, REQ_RESTORE: begin
            if (cls_r.badarg) begin
              rs_status_nxt = ST_BADARG;
            end else if (!cls_r.in_tab) begin
              rs_status_nxt = ST_RANGE;
            end else if (rd_live) begin
              rs_status_nxt = ST_EXISTS;
            end else if (cls_r.req == REQ_REGISTER) begin
              if (rd_last == GFULL) begin
                rs_status_nxt = ST_EXHAUSTED;
              end else begin
                we       = 1'b1;
                nw_live  = 1'b1;
                nw_last  = rd_last + GEN_BITS'(1);
                nw_egen  = rd_last + GEN_BITS'(1);
                nw_ls    = LC_REGISTERED;
                live_nxt = live_r + (IDX_W+1)'(1);
                rs_id_nxt  = 32'(idx_r);
                rs_gen_nxt = HGEN_W'(nw_egen);
              end
            end else begin
              we       = 1'b1;
              nw_live  = 1'b1;
              nw_egen  = GEN_BITS'(gen_r);
              nw_last  = (33'(gen_r) > 33'(rd_last)) ? GEN_BITS'(gen_r) : rd_last;
              nw_ls    = sv_r;
              live_nxt = live_r + (IDX_W+1)'(1);
              rs_id_nxt  = 32'(idx_r);
              rs_gen_nxt = gen_r;
            end
          end
          REQ_UNREGISTER, REQ_SET_STATE: begin
            if (cls_r.badarg) begin
              rs_status_nxt = ST_BADARG;
            end else if (!cls_r.in_tab) begin
              rs_status_nxt = ST_RANGE;
            end else if (!rd_live || !gen_match) begin
              rs_status_nxt = ST_NOTFOUND;
            end else if (cls_r.req == REQ_UNREGISTER) begin
              we       = 1'b1;
              nw_live  = 1'b0;
              live_nxt = live_r - (IDX_W+1)'(1);
              if (dest_r != '1) begin
                dest_nxt = dest_r + 32'd1;
              end
            end else if (!legal_move(rd_ls, sv_r)) begin
              rs_status_nxt = ST_BADARG;
            end else begin
              we    = 1'b1;
              nw_ls = sv_r;
            end
          end
          REQ_CLASSIFY: begin
            if (cls_r.is_null) begin
              rs_val_nxt = VAL_NULL;
            end else if (!cls_r.in_tab) begin
              rs_val_nxt    = VAL_UNKNOWN;
              rs_status_nxt = ST_RANGE;
            end else if (!rd_live) begin
              rs_val_nxt = VAL_UNKNOWN;
            end else if (!gen_match) begin
              rs_val_nxt = VAL_STALE;
            end
          end
          default: begin
            rs_status_nxt = ST_BADARG;
          end
        endcase
        rs_life_nxt = (cls_r.in_tab && nw_live) ? nw_ls : LC_CONSTRUCTED;
      end
      S_SRD: begin
        raddr     = scan_r[IDX_W-1:0];
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (!rd_live && rd_last == '0) begin
          rs_id_nxt  = 32'(scan_r);
          cursor_nxt = (scan_inc >= SW'(IDS)) ? '0 : scan_inc[IDX_W-1:0];
          state_nxt  = S_OUT;
        end else if (scan_inc >= SW'(IDS)) begin
          rs_status_nxt = ST_RANGE;
          state_nxt     = S_OUT;
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = S_SRD;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          o_load    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    wdata  = {nw_live, nw_last, nw_egen, nw_ls};
    ov_nxt = o_load || (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      cursor_r <= '0;
      live_r   <= '0;
      dest_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cursor_r <= cursor_nxt;
      live_r   <= live_nxt;
      dest_r   <= dest_nxt;
      ov_r     <= ov_nxt;
    end
    cls_r       <= cls_nxt;
    idx_r       <= idx_nxt;
    gen_r       <= gen_nxt;
    sv_r        <= sv_nxt;
    scan_r      <= scan_nxt;
    rs_status_r <= rs_status_nxt;
    rs_id_r     <= rs_id_nxt;
    rs_gen_r    <= rs_gen_nxt;
    rs_val_r    <= rs_val_nxt;
    rs_life_r   <= rs_life_nxt;
    if (o_load) begin
      o_status_r <= rs_status_r;
      o_id_r     <= rs_id_r;
      o_gen_r    <= rs_gen_r;
      o_val_r    <= rs_val_r;
      o_life_r   <= rs_life_r;
      o_live_r   <= live_r;
      o_dest_r   <= dest_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_status          = o_status_r;
  assign out_id              = o_id_r;
  assign out_gen             = o_gen_r;
  assign out_validity        = o_val_r;
  assign out_lifecycle       = o_life_r;
  assign out_live_count      = o_live_r;
  assign out_destroyed_count = o_dest_r;

endmodule

// ----- rtl/generational_handle_table_top.sv -----
// Generational handle table: front end, request queue, table sequencer, config port.
// A table request is popped and its slot read in the idle state, executed on the read data,
// then loaded into the output register; a reserve scans, reading then checking one slot at a time.
// The sequencer takes no new request until it has loaded the last result into its output register.
// Reset: synchronous, active low; afterwards the sequencer clears all IDS table slots,
// one per cycle, and takes no request until they are clear (configuration writes still land).
module generational_handle_table_top import hgt_pkg::*; #(
  parameter int IDS      = 1024,
  parameter int GEN_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_req_type,
  input  logic [31:0]                in_entity_id,
  input  logic [HGEN_W-1:0]          in_handle_gen,
  input  logic [2:0]                 in_state_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [31:0]                out_out_id,
  output logic [HGEN_W-1:0]          out_out_gen,
  output logic [1:0]                 out_validity,
  output logic [2:0]                 out_lifecycle,
  output logic [$clog2(IDS):0]       out_live_count,
  output logic [31:0]                out_destroyed_count,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IDX_W = $clog2(IDS);
  localparam int QW    = CLS_W + IDX_W + HGEN_W + 3;

  hgt_cls_t          f_cls, q_cls;
  logic [IDX_W-1:0]  f_idx, q_idx;
  logic [HGEN_W-1:0] q_gen;
  logic [2:0]        q_sv;
  logic [QW-1:0]     q_head;
  logic              q_empty, q_full, q_pop, push;
  logic [BASE_W-1:0] base_r, base_nxt;

  hgt_front #(.IDX_W(IDX_W), .IDS(IDS), .GEN_BITS(GEN_BITS)) u_front (
    .req_type    (in_req_type),
    .entity_id   (in_entity_id),
    .handle_gen  (in_handle_gen),
    .state_value (in_state_value),
    .cls         (f_cls),
    .idx         (f_idx)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  hgt_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cls, f_idx, in_handle_gen, in_state_value}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {q_cls, q_idx, q_gen, q_sv} = q_head;

  hgt_back #(.IDS(IDS), .IDX_W(IDX_W), .GEN_BITS(GEN_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (!q_empty),
    .q_cls               (q_cls),
    .q_idx               (q_idx),
    .q_gen               (q_gen),
    .q_sv                (q_sv),
    .q_pop               (q_pop),
    .reserve_base        (base_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_id              (out_out_id),
    .out_gen             (out_out_gen),
    .out_validity        (out_validity),
    .out_lifecycle       (out_lifecycle),
    .out_live_count      (out_live_count),
    .out_destroyed_count (out_destroyed_count)
  );

  // Only one register, selected while address bit 2 is low (byte addresses 0 to 3, index 0).
  always_comb begin
    base_nxt = base_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      base_nxt = cfg_pwdata[BASE_W-1:0];
    end
    cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(base_r);
    cfg_pready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

endmodule
